>>> rtl/dqdm_pkg.sv
// Shared constants and elaboration-time helpers for the DQPSK differential demapper.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package dqdm_pkg;

   // Frame symbol counter and frame length register width
   localparam int COUNT_W = 16;

   // round(2^(width-1) / sqrt(2)) by bitwise integer square root of 2^(2*width-3)
   function automatic longint ref_magnitude(input int width);
      longint n;
      longint r;
      longint t;
      longint step;
      n    = longint'(1) << (2 * width - 3);
      r    = 0;
      step = longint'(1) << width;
      while (step != 0) begin
         t = r | step;
         if (t * t <= n) begin
            r = t;
         end
         step = step >> 1;
      end
      // round to nearest: bump when (r + 1/2)^2 <= n
      if (4 * r * r + 4 * r + 1 <= 4 * n) begin
         r = r + 1;
      end
      return r;
   endfunction

endpackage

>>> rtl/dqdm_if.sv
// Valid/ready stream interfaces for the demapper sample input and soft-decision output.
// Depends on nothing; widths follow SAMPLE_WIDTH.
`timescale 1ns / 1ps

interface dqdm_req_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_i;
   logic signed [SAMPLE_WIDTH-1:0] sample_q;

   modport source (output valid, output sample_i, output sample_q, input ready);
   modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

interface dqdm_rsp_if #(parameter int SAMPLE_WIDTH = 16);
   logic                             valid;
   logic                             ready;
   logic signed [2*SAMPLE_WIDTH:0]   out_i;
   logic signed [2*SAMPLE_WIDTH:0]   out_q;

   modport source (output valid, output out_i, output out_q, input ready);
   modport sink   (input valid, input out_i, input out_q, output ready);
endinterface

>>> rtl/dqdm_cmul.sv
// Complex multiply x * conj(d) with the conjugate already applied to d, one result register.
// Depends on dqdm_rsp_if for the result channel.
`timescale 1ns / 1ps

module dqdm_cmul #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] op_a,
   input  logic signed [SAMPLE_WIDTH-1:0] op_b,
   input  logic signed [SAMPLE_WIDTH-1:0] op_c,
   input  logic signed [SAMPLE_WIDTH-1:0] op_e,
   dqdm_rsp_if.source                     rsp
);

   localparam int PW = 2 * SAMPLE_WIDTH;   // product width
   localparam int OW = PW + 1;             // sum width

   logic                   res_valid_ff;
   logic signed [PW-1:0]   prod_ac, prod_be, prod_ae, prod_bc;
   logic signed [OW-1:0]   out_i_ff, out_q_ff;
   logic signed [OW-1:0]   out_i_in, out_q_in;

   // result register takes new data when empty or when the receiver drains it
   assign in_ready = !res_valid_ff || rsp.ready;

   // four independent partial products
   assign prod_ac = PW'(op_a) * PW'(op_c);
   assign prod_be = PW'(op_b) * PW'(op_e);
   assign prod_ae = PW'(op_a) * PW'(op_e);
   assign prod_bc = PW'(op_b) * PW'(op_c);

   // real = ac - be, imag = ae + bc, full precision
   assign out_i_in = OW'(prod_ac) - OW'(prod_be);
   assign out_q_in = OW'(prod_ae) + OW'(prod_bc);

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (in_ready) begin
         res_valid_ff <= in_valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         out_i_ff <= out_i_in;
         out_q_ff <= out_q_in;
      end
   end

   assign rsp.valid = res_valid_ff;
   assign rsp.out_i = out_i_ff;
   assign rsp.out_q = out_q_ff;

endmodule

>>> rtl/dqsk_placeholder_unused.sv
// Intentionally minimal: not part of the build order.
`timescale 1ns / 1ps

>>> rtl/dqpsk_differential_demapper_top.sv
// DQPSK differential demapper: usage notes
//   req_ch  : complex sample stream (sample_i, sample_q), signed fixed point of
//             SAMPLE_WIDTH bits, valid/ready; a transfer happens when both are high.
//   rsp_ch  : one result per sample, out_i/out_q = sample * conj(sample DELAY
//             transfers earlier), full precision, 2*SAMPLE_WIDTH+1 bits.
//   csr_wr_en / csr_wr_data : frame length in samples; write only while idle.
// Every FRAME-th sample clears the symbol counter and reloads the whole delay
// line with exp(-j*pi/4), so the first DELAY results of each frame use it.
// An input transfer reaches rsp_ch.valid through the operand register, then the
// result register behind the complex multiply. Throughput: one sample per cycle
// while the receiver takes results; the delay line and counter update in the
// cycle of the transfer, so back-to-back samples need no wait.
// A stalled receiver holds the result register; the operand register still takes
// one more sample and req_ch.ready drops only once both stages hold data.
// Reset (synchronous): empties the pipeline, loads the reference into the
// delay line, clears the counter and sets the frame length to 1.
// Depends on dqdm_pkg, dqdm_if.sv and dqdm_cmul.
`timescale 1ns / 1ps

module dqpsk_differential_demapper_top #(
   parameter int DELAY        = 4,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   dqdm_req_if.sink                      req_ch,
   dqdm_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [dqdm_pkg::COUNT_W-1:0]  csr_wr_data
);

   import dqdm_pkg::*;

   localparam int DW = (DELAY > 1) ? $clog2(DELAY) : 1;
   localparam logic signed [SAMPLE_WIDTH-1:0] REF_MAG =
      SAMPLE_WIDTH'(ref_magnitude(SAMPLE_WIDTH));
   localparam logic signed [SAMPLE_WIDTH-1:0] NEG_REF = -REF_MAG;
   localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [DW-1:0] LAST = DW'(DELAY - 1);

   logic signed [SAMPLE_WIDTH-1:0] dr_ff [DELAY];
   logic signed [SAMPLE_WIDTH-1:0] di_ff [DELAY];
   logic [COUNT_W-1:0]             count_ff;
   logic [COUNT_W-1:0]             count_in;
   logic [COUNT_W-1:0]             frame_len_ff;
   logic                           frame_end;
   logic signed [SAMPLE_WIDTH-1:0] conj_q;

   logic                           op_valid_ff;
   logic                           op_ready;
   logic                           cmul_ready;
   logic                           req_xfer;
   logic signed [SAMPLE_WIDTH-1:0] op_a_ff, op_b_ff, op_c_ff, op_e_ff;

   // operand stage handshake
   assign op_ready     = !op_valid_ff || cmul_ready;
   assign req_ch.ready = op_ready;
   assign req_xfer     = req_ch.valid && op_ready;

   // frame counter and conjugate of the incoming Q, saturated at the negative end
   assign count_in  = count_ff + 1'b1;
   assign frame_end = (count_in == frame_len_ff);
   assign conj_q    = (req_ch.sample_q == S_MIN) ? S_MAX : -req_ch.sample_q;

   // control, delay line and frame length
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DELAY; k++) begin
            dr_ff[k] <= REF_MAG;
            di_ff[k] <= NEG_REF;
         end
         count_ff     <= '0;
         frame_len_ff <= COUNT_W'(1);
         op_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            frame_len_ff <= csr_wr_data;
         end
         if (op_ready) begin
            op_valid_ff <= req_ch.valid;
         end
         if (req_xfer) begin
            if (frame_end) begin
               for (int k = 0; k < DELAY; k++) begin
                  dr_ff[k] <= REF_MAG;
                  di_ff[k] <= NEG_REF;
               end
               count_ff <= '0;
            end else begin
               for (int k = DELAY - 1; k > 0; k--) begin
                  dr_ff[k] <= dr_ff[k-1];
                  di_ff[k] <= di_ff[k-1];
               end
               dr_ff[0] <= req_ch.sample_i;
               di_ff[0] <= conj_q;
               count_ff <= count_in;
            end
         end
      end
   end

   // operand register: sample and the oldest delay tap
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_a_ff <= req_ch.sample_i;
         op_b_ff <= req_ch.sample_q;
         op_c_ff <= dr_ff[LAST];
         op_e_ff <= di_ff[LAST];
      end
   end

   dqdm_cmul #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_cmul (
      .clock    (clock),
      .reset    (reset),
      .in_valid (op_valid_ff),
      .in_ready (cmul_ready),
      .op_a     (op_a_ff),
      .op_b     (op_b_ff),
      .op_c     (op_c_ff),
      .op_e     (op_e_ff),
      .rsp      (rsp_ch)
   );

   // a frame boundary leaves the whole line at the reference
   a_reload : assert property (@(posedge clock) disable iff (reset)
      req_xfer && frame_end |=> dr_ff[LAST] == REF_MAG && di_ff[LAST] == NEG_REF
         && dr_ff[0] == REF_MAG && di_ff[0] == NEG_REF && count_ff == '0)
      else $error("delay line not reloaded at frame end");

   // counter moves by one per transfer or restarts
   a_count : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> count_ff == $past(count_in) || count_ff == '0)
      else $error("symbol counter skipped");

   // stored conjugate never holds the unrepresentable negative extreme
   a_conj : assert property (@(posedge clock) disable iff (reset)
      di_ff[0] != S_MIN)
      else $error("conjugate entry not saturated");

endmodule

>>> tb/testbench.sv
// Self-checking bench for dqpsk_differential_demapper_top: random and directed Q1.15 samples,
// an in-bench differential product predictor, and per-field checks of every Q3.30 result.
// Depends on rtl/dqdm_pkg.sv, rtl/dqdm_if.sv and the demapper RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int NUM_TAPS      = 4;
   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_CYCLES   = 80;
   localparam int MAX_PRINTS    = 50;
   localparam int ITEMS_PER_LEN = 135;
   localparam int EDGE_ITEMS    = 60;

   typedef logic signed [15:0] sample_type;
   typedef logic signed [32:0] soft_type;
   typedef struct packed {
      soft_type out_i;
      soft_type out_q;
   } soft_pair_type;

   // cos(pi/4) in Q1.15; the reference phasor is PI4_MAG - j*PI4_MAG
   localparam sample_type PI4_MAG = 16'sd23170;
   localparam sample_type S_MAX   = 16'sh7FFF;
   localparam sample_type S_MIN   = 16'sh8000;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         csr_wr_en   = 1'b0;
   logic [dqdm_pkg::COUNT_W-1:0] csr_wr_data = '0;

   dqdm_req_if #(.SAMPLE_WIDTH(16)) req_ch ();
   dqdm_rsp_if #(.SAMPLE_WIDTH(16)) rsp_ch ();

   dqpsk_differential_demapper_top #(
      .DELAY       (NUM_TAPS),
      .SAMPLE_WIDTH(16)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state: conjugated past samples, symbol counter, frame length
   sample_type    conj_re [NUM_TAPS];
   sample_type    conj_im [NUM_TAPS];
   logic [15:0]   sym_count;
   logic [15:0]   frame_len;
   soft_pair_type pending_products [$];

   int error_count = 0;
   int idle_cycles = 0;
   int burst_left  = 0;
   bit gaps_on      = 1'b1;
   bit hold_request = 1'b0;

   function automatic void reload_reference();
      for (int k = 0; k < NUM_TAPS; k++) begin
         conj_re[k] = PI4_MAG;
         conj_im[k] = -PI4_MAG;
      end
   endfunction

   // Product of one sample with the conjugate of the sample NUM_TAPS transfers back,
   // then advance the delay line and the frame counter
   function automatic soft_pair_type demap_sample(sample_type a, sample_type b);
      soft_pair_type p;
      longint        c, e, re, im, nb;
      c  = conj_re[NUM_TAPS-1];
      e  = conj_im[NUM_TAPS-1];
      re = longint'(a) * c - longint'(b) * e;
      im = longint'(a) * e + longint'(b) * c;
      p.out_i = re[32:0];
      p.out_q = im[32:0];
      // conjugate of the most negative Q saturates
      nb = -longint'(b);
      if (nb > 32767) nb = 32767;
      for (int k = NUM_TAPS - 1; k > 0; k--) begin
         conj_re[k] = conj_re[k-1];
         conj_im[k] = conj_im[k-1];
      end
      conj_re[0] = a;
      conj_im[0] = nb[15:0];
      sym_count = sym_count + 16'd1;
      if (sym_count == frame_len) begin
         reload_reference();
         sym_count = '0;
      end
      return p;
   endfunction

   function automatic sample_type random_sample();
      case ($urandom_range(0, 9))
         0:       return S_MIN;
         1:       return S_MAX;
         2:       return $urandom_range(0, 1) ? sample_type'(-1) : sample_type'(0);
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input soft_type got,
                                  input soft_type want);
      if (error_count < MAX_PRINTS)
         $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // One input transfer; the sender runs in bursts with random gaps between them
   task automatic send_sample(input sample_type si, input sample_type sq);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 7) : 0;
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_ch.valid    <= 1'b1;
      req_ch.sample_i <= si;
      req_ch.sample_q <= sq;
      do @(posedge clock); while (!req_ch.ready);
      pending_products.push_back(demap_sample(si, sq));
   endtask

   // Stop offering and wait until every outstanding result has come back
   task automatic wait_for_products();
      req_ch.valid <= 1'b0;
      while (pending_products.size() != 0) @(posedge clock);
   endtask

   task automatic write_frame_length(input logic [15:0] value);
      wait_for_products();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      frame_len = value;
   endtask

   task automatic send_random(input int count);
      repeat (count) send_sample(random_sample(), random_sample());
   endtask

   // Reset frame length of one: every result uses the reference phasor
   task automatic test_reset_frame();
      send_sample(S_MAX, S_MAX);
      send_sample(S_MIN, S_MIN);
      send_sample(S_MAX, S_MIN);
      send_sample(S_MIN, S_MAX);
      send_sample(16'sd0, 16'sd0);
      wait_for_products();
   endtask

   // Field extremes against extreme delayed samples, incl. saturated conjugate
   task automatic test_directed_extremes();
      sample_type dir_i [14] = '{S_MIN, S_MAX, S_MIN, S_MAX, 16'sd0, -16'sd1, 16'sd1,
                                 16'sd0, S_MIN, S_MAX, S_MIN, S_MAX, 16'sh5555, 16'sh2AAA};
      sample_type dir_q [14] = '{S_MIN, S_MAX, S_MAX, S_MIN, S_MIN, -16'sd1, -16'sd1,
                                 16'sd0, S_MIN, S_MIN, 16'sd0, S_MAX, 16'shAAAA, 16'sh5555};
      write_frame_length(16'd64);
      for (int k = 0; k < 14; k++) send_sample(dir_i[k], dir_q[k]);
      wait_for_products();
   endtask

   // Long receiver hold while the sender keeps offering, so the pipeline fills
   task automatic test_backpressure();
      gaps_on      = 1'b0;
      burst_left   = 0;
      hold_request = 1'b1;
      send_random(40);
      gaps_on = 1'b1;
      wait_for_products();
   endtask

   task automatic test_random_frames();
      logic [15:0] lengths [9] = '{16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd13, 16'd64,
                                   16'd1, 16'd0};
      foreach (lengths[k]) begin
         write_frame_length(lengths[k] != 16'd0 ? lengths[k] : 16'($urandom_range(1, 400)));
         send_random(ITEMS_PER_LEN);
      end
      wait_for_products();
   endtask

   // Largest frame length: the count stays below it, so no reload happens
   task automatic test_frame_length_max();
      write_frame_length(16'hFFFF);
      send_random(EDGE_ITEMS);
      wait_for_products();
   endtask

   // Frame length zero: the counter runs on with no reload short of a wrap
   task automatic test_counter_wrap();
      write_frame_length(16'd0);
      send_random(EDGE_ITEMS);
      wait_for_products();
   endtask

   // Length set below the running count: no reload until the counter wraps
   task automatic test_length_below_count();
      write_frame_length(16'd3);
      send_random(EDGE_ITEMS);
      wait_for_products();
   endtask

   // Receiver: long hold on request, otherwise full rate, a rotating pattern or random
   initial begin : rsp_stall_pattern
      int          hold_left;
      int          mode;
      int          cyc;
      logic [15:0] pattern;
      hold_left = 0;
      mode      = 0;
      cyc       = 0;
      pattern   = 16'hFFFF;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (cyc % 96 == 0) begin
            mode    = $urandom_range(0, 2);
            pattern = 16'($urandom) | 16'h0101;
         end
         cyc++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (mode == 0) begin
            rsp_ch.ready <= 1'b1;
         end else if (mode == 1) begin
            rsp_ch.ready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin : check_products
      soft_pair_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_products.size() == 0) begin
            report_mismatch("result with no sample outstanding, out_i", rsp_ch.out_i, '0);
         end else begin
            want = pending_products.pop_front();
            if (rsp_ch.out_i !== want.out_i) report_mismatch("out_i", rsp_ch.out_i, want.out_i);
            if (rsp_ch.out_q !== want.out_q) report_mismatch("out_q", rsp_ch.out_q, want.out_q);
         end
      end
   end

   // Watchdog: cycles without any transfer on either channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      req_ch.valid    <= 1'b0;
      req_ch.sample_i <= '0;
      req_ch.sample_q <= '0;
      reload_reference();
      sym_count = '0;
      frame_len = 16'd1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_frame();
      test_directed_extremes();
      test_backpressure();
      test_random_frames();
      test_frame_length_max();
      test_counter_wrap();
      test_length_below_count();

      wait_for_products();
      repeat (10) @(posedge clock);
      if (pending_products.size() != 0)
         report_mismatch("predictions left over, count",
                         soft_type'(pending_products.size()), '0);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
